### rtl/mqr_pkg.sv
// Shared types, field widths, codes and defaults of the multi-queue request ring.
package mqr_pkg;

	localparam int HANDLE_W   = 32;
	localparam int TYPE_W     = 4;
	localparam int QIDX_W     = 3;
	localparam int QUEUES_W   = 4;
	localparam int DEPTH_W    = 7;
	localparam int BUDGET_W   = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam int DEF_MAX_QUEUES = 8;
	localparam int DEF_MAX_DEPTH  = 64;
	localparam int DEF_MAX_BUDGET = 32;

	localparam logic [QUEUES_W-1:0] RST_QUEUES = QUEUES_W'(8);
	localparam logic [DEPTH_W-1:0]  RST_DEPTH  = DEPTH_W'(64);
	localparam logic [BUDGET_W-1:0] RST_BUDGET = BUDGET_W'(32);

	// The steering remainder consumes this many handle bits per cycle.
	localparam int MOD_DIGIT_W = 4;
	localparam int MOD_STEPS   = HANDLE_W / MOD_DIGIT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUES = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = CFG_IDX_W'(2);

	localparam logic FUNC_SUBMIT = 1'b0;
	localparam logic FUNC_DRAIN  = 1'b1;

	typedef enum logic [1:0] {
		OUT_ACCEPTED = 2'd0,
		OUT_FULL     = 2'd1,
		OUT_POPPED   = 2'd2,
		OUT_EMPTY    = 2'd3
	} outcome_t;

	typedef struct packed {
		logic                func;
		logic [HANDLE_W-1:0] request_handle;
		logic [TYPE_W-1:0]   request_type;
	} req_t;

	typedef struct packed {
		outcome_t            outcome;
		logic [QIDX_W-1:0]   queue_index;
		logic [HANDLE_W-1:0] popped_handle;
		logic [TYPE_W-1:0]   popped_type;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic [TYPE_W-1:0]   slot_type;
		logic [HANDLE_W-1:0] slot_handle;
	} slot_t;

endpackage

### rtl/multi_queue_request_ring.sv
// Top level of the multi-queue request ring: sequencer, queue pointers and result path.
//
// A command is taken on a clock edge where start is high and busy is low; request
// carries func, request_handle and request_type. Results appear on result for one
// cycle each, flagged by result_valid, and the receiver cannot hold them off.
// A submit steers its handle to queue (handle xor type) mod queues_in_use. The
// remainder unit works four handle bits per cycle, so a submit keeps busy high
// until the remainder is done and gives its single result in the last busy cycle.
// A drain walks the queues from index 0 and pops one entry per cycle while the
// current queue is not empty, else moves on; it stops at the budget or after the
// last queue. Results follow at up to one per cycle and the final one has last set.
// The slot memory has one read and one write port; a popped slot's data is
// registered and then held until the next pop's data arrives or the scan closes,
// so each pop result leaves from the pending register, not with its read.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while busy is low, as the block does not enforce it. Reset restores
// the register defaults and empties each queue by clearing head and tail, not the slots.
module multi_queue_request_ring #(
	parameter int MAX_QUEUES = mqr_pkg::DEF_MAX_QUEUES,
	parameter int MAX_DEPTH  = mqr_pkg::DEF_MAX_DEPTH,
	parameter int MAX_BUDGET = mqr_pkg::DEF_MAX_BUDGET
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  mqr_pkg::req_t                   request,
	output logic                            result_valid,
	output mqr_pkg::rsp_t                   result,
	input  logic                            cfg_we,
	input  logic [mqr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mqr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mqr_pkg::*;

	localparam int QW    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int NQW   = $clog2(MAX_QUEUES + 1);
	localparam int PW    = $clog2(MAX_DEPTH);
	localparam int NW    = PW + 1;
	localparam int DW    = $clog2(MAX_DEPTH + 1);
	localparam int BW    = $clog2(MAX_BUDGET + 1);
	localparam int SLOTS = MAX_QUEUES * MAX_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int SW    = $bits(slot_t);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MOD    = 5'b00010,
		ST_SUBMIT = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t              state_q;
	logic [QUEUES_W-1:0] queues_q;
	logic [DEPTH_W-1:0]  depth_cfg_q;
	logic [BUDGET_W-1:0] budget_cfg_q;
	logic [NQW-1:0]      nq;
	logic [DW-1:0]       depth;
	logic [BW-1:0]       budget;

	req_t                req_q;
	logic [NQW-1:0]      cur_q_q;
	logic [BW-1:0]       cnt_q;
	logic [PW-1:0]       head_q [MAX_QUEUES];
	logic [PW-1:0]       tail_q [MAX_QUEUES];

	logic [QW-1:0]       q_idx;
	logic [PW-1:0]       head_cur;
	logic [PW-1:0]       tail_cur;
	logic [PW-1:0]       head_nxt;
	logic [PW-1:0]       tail_nxt;
	logic                q_full;
	logic                q_empty;
	logic                drain_stop;
	logic                accept;
	logic                push;
	logic                pop;

	logic                mod_load;
	logic                mod_done;
	logic [NQW-1:0]      mod_rem;

	slot_t               wr_slot;
	slot_t               rd_slot;
	logic [SW-1:0]       rd_bits;
	logic                rd_valid_s1;
	logic [QW-1:0]       rd_q_s1;
	logic                pend_valid_q;
	slot_t               pend_slot_q;
	logic [QW-1:0]       pend_qidx_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p, input logic [DW-1:0] d);
		logic [NW-1:0] n;
		n = NW'(p) + NW'(1);
		if (n >= NW'(d)) begin
			return '0;
		end
		return n[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q, input logic [PW-1:0] p);
		return AW'(q) * AW'(MAX_DEPTH) + AW'(p);
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queues_q     <= RST_QUEUES;
			depth_cfg_q  <= RST_DEPTH;
			budget_cfg_q <= RST_BUDGET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUEUES: queues_q     <= cfg_data[QUEUES_W-1:0];
				CFG_DEPTH:  depth_cfg_q  <= cfg_data[DEPTH_W-1:0];
				CFG_BUDGET: budget_cfg_q <= cfg_data[BUDGET_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range register values are clamped into their legal ranges.
	always_comb begin
		if (queues_q == '0) begin
			nq = NQW'(1);
		end else if (int'(queues_q) > MAX_QUEUES) begin
			nq = NQW'(MAX_QUEUES);
		end else begin
			nq = NQW'(queues_q);
		end
		if (int'(depth_cfg_q) < 2) begin
			depth = DW'(2);
		end else if (int'(depth_cfg_q) > MAX_DEPTH) begin
			depth = DW'(MAX_DEPTH);
		end else begin
			depth = DW'(depth_cfg_q);
		end
		if (budget_cfg_q == '0) begin
			budget = BW'(1);
		end else if (int'(budget_cfg_q) > MAX_BUDGET) begin
			budget = BW'(MAX_BUDGET);
		end else begin
			budget = BW'(budget_cfg_q);
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign q_idx      = cur_q_q[QW-1:0];
	assign head_cur   = head_q[q_idx];
	assign tail_cur   = tail_q[q_idx];
	assign head_nxt   = next_ptr(head_cur, depth);
	assign tail_nxt   = next_ptr(tail_cur, depth);
	assign q_full     = (tail_nxt == head_cur);
	assign q_empty    = (head_cur == tail_cur);
	assign drain_stop = (cnt_q == budget) || (cur_q_q == nq);
	assign push       = (state_q == ST_SUBMIT) && !q_full;
	assign pop        = (state_q == ST_DRAIN) && !drain_stop && !q_empty;
	assign mod_load   = accept && (request.func == FUNC_SUBMIT);

	assign wr_slot.slot_type   = req_q.request_type;
	assign wr_slot.slot_handle = req_q.request_handle;
	assign rd_slot             = slot_t'(rd_bits);

	mqr_mod_unit #(
		.NQW(NQW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (mod_load),
		.dividend (request.request_handle ^ HANDLE_W'(request.request_type)),
		.divisor  (nq),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	mqr_slot_mem #(
		.DEPTH(SLOTS),
		.WIDTH(SW)
	) u_mem (
		.clk  (clk),
		.we   (push),
		.waddr(slot_addr(q_idx, tail_cur)),
		.wdata(SW'(wr_slot)),
		.re   (pop),
		.raddr(slot_addr(q_idx, head_cur)),
		.rdata(rd_bits)
	);

	// Sequencer and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q_q      <= '0;
			cnt_q        <= '0;
			rd_valid_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			rd_valid_s1 <= pop;
			if (rd_valid_s1) begin
				pend_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (request.func == FUNC_DRAIN) begin
							state_q <= ST_DRAIN;
							cur_q_q <= '0;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						cur_q_q <= mod_rem;
						state_q <= ST_SUBMIT;
					end
				end
				ST_SUBMIT: begin
					if (push) begin
						tail_q[q_idx] <= tail_nxt;
					end
					state_q <= ST_IDLE;
				end
				ST_DRAIN: begin
					if (drain_stop) begin
						state_q <= ST_FIN;
					end else if (!q_empty) begin
						head_q[q_idx] <= head_nxt;
						cnt_q         <= cnt_q + 1'b1;
					end else begin
						cur_q_q <= cur_q_q + 1'b1;
					end
				end
				ST_FIN: begin
					pend_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A popped entry is held in a pending register so that last can be set on whichever pop
	// turns out to be the final one.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (pop) begin
			rd_q_s1 <= q_idx;
		end
		if (rd_valid_s1) begin
			pend_slot_q <= rd_slot;
			pend_qidx_q <= rd_q_s1;
		end
	end

	always_comb begin
		result_valid = 1'b0;
		result       = '0;
		case (state_q)
			ST_SUBMIT: begin
				result_valid       = 1'b1;
				result.outcome     = q_full ? OUT_FULL : OUT_ACCEPTED;
				result.queue_index = QIDX_W'(q_idx);
				result.last        = 1'b1;
			end
			ST_DRAIN: begin
				if (rd_valid_s1 && pend_valid_q) begin
					result_valid         = 1'b1;
					result.outcome       = OUT_POPPED;
					result.queue_index   = QIDX_W'(pend_qidx_q);
					result.popped_handle = pend_slot_q.slot_handle;
					result.popped_type   = pend_slot_q.slot_type;
				end
			end
			ST_FIN: begin
				result_valid = 1'b1;
				result.last  = 1'b1;
				if (pend_valid_q) begin
					result.outcome       = OUT_POPPED;
					result.queue_index   = QIDX_W'(pend_qidx_q);
					result.popped_handle = pend_slot_q.slot_handle;
					result.popped_type   = pend_slot_q.slot_type;
				end else begin
					result.outcome = OUT_EMPTY;
				end
			end
			default: ;
		endcase
	end

	a_submit_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUBMIT |-> result_valid && result.last)
		else $error("submit cycle without a final result");

	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> state_q == ST_IDLE)
		else $error("final result not followed by idle");

	a_read_lands_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> state_q == ST_DRAIN)
		else $error("slot read returned outside the drain scan");

	a_budget_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> cnt_q <= budget)
		else $error("drain popped more than the budget");

endmodule

### rtl/mqr_mod_unit.sv
// Iterative remainder unit: reduces a handle modulo a small queue count, one digit per cycle.
module mqr_mod_unit #(
	parameter int NQW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [mqr_pkg::HANDLE_W-1:0]  dividend,
	input  logic [NQW-1:0]                divisor,
	output logic                          done,
	output logic [NQW-1:0]                remainder
);
	import mqr_pkg::*;

	localparam int CntW = $clog2(MOD_STEPS + 1);

	logic [HANDLE_W-1:0] val_q;
	logic [NQW-1:0]      rem_q;
	logic [NQW-1:0]      rem_next;
	logic [CntW-1:0]     cnt_q;

	// Restoring steps: the partial remainder stays below the divisor, so one
	// compare and subtract per bit keeps it reduced.
	always_comb begin
		logic [NQW:0] acc;
		acc      = '0;
		rem_next = rem_q;
		for (int i = 0; i < MOD_DIGIT_W; i++) begin
			acc = {rem_next, val_q[HANDLE_W-1-i]};
			if (acc >= {1'b0, divisor}) begin
				acc = acc - {1'b0, divisor};
			end
			rem_next = acc[NQW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CntW'(MOD_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			val_q <= val_q << MOD_DIGIT_W;
			rem_q <= rem_next;
		end
	end

	assign done      = (cnt_q == '0);
	assign remainder = rem_q;

endmodule

### rtl/mqr_slot_mem.sv
// Single-port-write, single-port-read slot memory with registered read data.
module mqr_slot_mem #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
